/* rtl/obstacle_detour_sequencer_assert.svh */
// Assertion macros used by the RTL of the obstacle detour sequencer.
`ifndef OBSTACLE_DETOUR_SEQUENCER_ASSERT_SVH
`define OBSTACLE_DETOUR_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ODS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obstacle detour sequencer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ODS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obstacle detour sequencer: next-cycle check failed");

`endif

/* rtl/ods_pkg.sv */
`default_nettype none

package ods_pkg;

    // Field widths.
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned IR_W    = 16;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESET  = 2'd3;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_INACTIVE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DETECT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RIGHT    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FORWARD  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEFT     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE     = 3'd5;

    // Motor command codes.
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TLEFT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TRIGHT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SLEFT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SRIGHT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd6;

    // Turn direction meaning straight right.
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LF    = 3'd5;

    // Configuration reset values.
    localparam logic [DIST_W-1:0]  RST_THRESHOLD = 16'd320;
    localparam logic [DUR_W-1:0]   RST_RIGHT_MS  = 16'd1000;
    localparam logic [DUR_W-1:0]   RST_FWD_MS    = 16'd1000;
    localparam logic [DUR_W-1:0]   RST_LEFT_MS   = 16'd3000;
    localparam logic [SPEED_W-1:0] RST_SPEED     = 8'd100;

    // Most commands one item can cause.
    localparam int unsigned MAX_CMDS = 3;

    // One queued motor command.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SPEED_W-1:0] speed;
    } t_cmd_entry;

endpackage

`default_nettype wire

/* rtl/ods_in_if.sv */
`default_nettype none

// Input channel: one item per beat.
interface ods_in_if;
    logic                                valid;
    logic                                ready;
    logic [ods_pkg::FUNC_W-1:0]          func;
    logic [ods_pkg::TIME_W-1:0]          now_ms;
    logic                                distance_valid;
    logic [ods_pkg::DIST_W-1:0]          distance;
    logic                                ir_valid;
    logic [ods_pkg::IR_W-1:0]            ir_mid_left;
    logic [ods_pkg::IR_W-1:0]            ir_mid_right;
    logic signed [ods_pkg::DIR_W-1:0]    turn_dir;
    logic [ods_pkg::SPEED_W-1:0]         base_speed;

    modport source (
        output valid, func, now_ms, distance_valid, distance, ir_valid,
               ir_mid_left, ir_mid_right, turn_dir, base_speed,
        input  ready
    );

    modport sink (
        input  valid, func, now_ms, distance_valid, distance, ir_valid,
               ir_mid_left, ir_mid_right, turn_dir, base_speed,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ods_out_if.sv */
`default_nettype none

// Output channel: one motor command per beat.
interface ods_out_if;
    logic                            valid;
    logic                            ready;
    logic [ods_pkg::CMD_W-1:0]       motor_cmd;
    logic [ods_pkg::SPEED_W-1:0]     cmd_speed;
    logic [ods_pkg::PHASE_W-1:0]     phase;
    logic                            completed;
    logic                            last_result;

    modport source (
        output valid, motor_cmd, cmd_speed, phase, completed, last_result,
        input  ready
    );

    modport sink (
        input  valid, motor_cmd, cmd_speed, phase, completed, last_result,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/obstacle_detour_sequencer.sv */
// Flow: an accepted item waits in the input register until the result register is empty or
// drains its last beat, is then processed and loaded into the result register, and its first
// beat is on the output from then on. Throughput: one item per cycle while the output is ready
// and each item gives one beat; an item of two or three commands gives a beat per ready cycle.
// Reset: synchronous, active low; empties both registers, returns the phase to inactive,
// clears the action start time and loads the configuration defaults.
`default_nettype none

`include "obstacle_detour_sequencer_assert.svh"

module obstacle_detour_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ods_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [ods_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ods_in_if.sink                                   i_in,
    ods_out_if.source                                o_out
);
    import ods_pkg::*;

    // Configuration registers.
    logic [DIST_W-1:0]  r_threshold;
    logic [DUR_W-1:0]   r_right_ms;
    logic [DUR_W-1:0]   r_fwd_ms;
    logic [DUR_W-1:0]   r_left_ms;
    logic [SPEED_W-1:0] r_speed;
    logic               r_use_lf;

    // Sequencer state.
    logic [PHASE_W-1:0] r_phase;
    logic [TIME_W-1:0]  r_action_start;
    logic [PHASE_W-1:0] n_phase;
    logic [TIME_W-1:0]  n_action_start;

    // Input register.
    logic               r_in_valid;
    logic [FUNC_W-1:0]  r_in_func;
    logic [TIME_W-1:0]  r_in_now;
    logic               r_in_dvalid;
    logic [DIST_W-1:0]  r_in_dist;
    logic               r_in_irvalid;
    logic [IR_W-1:0]    r_in_irl;
    logic [IR_W-1:0]    r_in_irr;
    logic [DIR_W-1:0]   r_in_dir;
    logic [SPEED_W-1:0] r_in_bspeed;

    // Result register: queued commands, shifted out one per beat.
    logic               r_out_valid;
    t_cmd_entry         r_list [MAX_CMDS];
    logic [1:0]         r_cnt;
    logic [PHASE_W-1:0] r_out_phase;
    logic               r_out_done;
    t_cmd_entry         n_list [MAX_CMDS];
    logic [1:0]         n_cnt;

    logic               w_in_beat;
    logic               w_out_beat;
    logic               w_move;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_obstacle;
    logic               w_line_seen;
    t_cmd_entry         w_steer;

    // Handshake: the input moves on when the result register is empty or drains its last beat.
    assign w_out_beat = r_out_valid && o_out.ready;
    assign w_move     = r_in_valid && (!r_out_valid || (o_out.ready && (r_cnt == 2'd1)));
    assign i_in.ready = !r_in_valid || w_move;
    assign w_in_beat  = i_in.valid && i_in.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_right_ms  <= RST_RIGHT_MS;
            r_fwd_ms    <= RST_FWD_MS;
            r_left_ms   <= RST_LEFT_MS;
            r_speed     <= RST_SPEED;
            r_use_lf    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_RIGHT_MS:  r_right_ms  <= i_cfg_data;
                REG_FWD_MS:    r_fwd_ms    <= i_cfg_data;
                REG_LEFT_MS:   r_left_ms   <= i_cfg_data;
                REG_SPEED:     r_speed     <= i_cfg_data[SPEED_W-1:0];
                REG_USE_LF:    r_use_lf    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_beat) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in_func    <= i_in.func;
            r_in_now     <= i_in.now_ms;
            r_in_dvalid  <= i_in.distance_valid;
            r_in_dist    <= i_in.distance;
            r_in_irvalid <= i_in.ir_valid;
            r_in_irl     <= i_in.ir_mid_left;
            r_in_irr     <= i_in.ir_mid_right;
            r_in_dir     <= i_in.turn_dir;
            r_in_bspeed  <= i_in.base_speed;
        end
    end

    // Decoded conditions of the held item.
    assign w_elapsed   = r_in_now - r_action_start;
    assign w_obstacle  = r_in_dvalid && (r_in_dist < r_threshold);
    assign w_line_seen = r_in_irvalid && ((r_in_irl == '0) || (r_in_irr == '0));

    // Line-follow steering: right for one, left for any negative code, else straight on.
    always_comb begin
        w_steer.speed = r_in_bspeed;
        if (r_in_dir == DIR_RIGHT) begin
            w_steer.cmd = CMD_TRIGHT;
        end else if (r_in_dir[DIR_W-1]) begin
            w_steer.cmd = CMD_TLEFT;
        end else begin
            w_steer.cmd = CMD_FWD;
        end
    end

    // Phase step and the commands it issues.
    always_comb begin
        n_phase        = r_phase;
        n_action_start = r_action_start;
        n_cnt          = 2'd0;
        for (int k = 0; k < MAX_CMDS; k++) begin
            n_list[k] = '{cmd: CMD_NONE, speed: '0};
        end
        unique case (r_in_func)
            FUNC_START: begin
                if (r_phase == PH_INACTIVE) begin
                    n_phase = PH_DETECT;
                end
            end
            FUNC_STOP, FUNC_RESET: begin
                n_phase = PH_INACTIVE;
            end
            FUNC_UPDATE: begin
                unique case (r_phase)
                    PH_INACTIVE, PH_DONE: begin
                    end
                    PH_DETECT: begin
                        if (r_use_lf) begin
                            n_list[0] = w_steer;
                            n_cnt     = 2'd1;
                            if (w_obstacle) begin
                                n_list[1] = '{cmd: CMD_STOP, speed: '0};
                                n_list[2] = '{cmd: CMD_SRIGHT, speed: r_speed};
                                n_cnt     = 2'd3;
                            end
                        end else if (w_obstacle) begin
                            n_list[0] = '{cmd: CMD_STOP, speed: '0};
                            n_list[1] = '{cmd: CMD_SRIGHT, speed: r_speed};
                            n_cnt     = 2'd2;
                        end
                        if (w_obstacle) begin
                            n_action_start = r_in_now;
                            n_phase        = PH_RIGHT;
                        end
                    end
                    PH_RIGHT: begin
                        if (w_elapsed >= {{(TIME_W-DUR_W){1'b0}}, r_right_ms}) begin
                            n_list[0]      = '{cmd: CMD_FWD, speed: r_speed};
                            n_cnt          = 2'd1;
                            n_action_start = r_in_now;
                            n_phase        = PH_FORWARD;
                        end
                    end
                    PH_FORWARD: begin
                        if (w_elapsed >= {{(TIME_W-DUR_W){1'b0}}, r_fwd_ms}) begin
                            n_list[0]      = '{cmd: CMD_SLEFT, speed: r_speed};
                            n_cnt          = 2'd1;
                            n_action_start = r_in_now;
                            n_phase        = PH_LEFT;
                        end
                    end
                    PH_LEFT: begin
                        if (w_line_seen
                            || (w_elapsed >= {{(TIME_W-DUR_W){1'b0}}, r_left_ms})) begin
                            n_list[0] = '{cmd: CMD_STOP, speed: '0};
                            n_cnt     = 2'd1;
                            n_phase   = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = PH_INACTIVE;
                    end
                endcase
            end
        endcase
        // An item without a command still gives one beat carrying the phase.
        if (n_cnt == 2'd0) begin
            n_cnt = 2'd1;
        end
    end

    // Sequencer state advances as the item enters the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_INACTIVE;
            r_action_start <= '0;
        end else if (w_move) begin
            r_phase        <= n_phase;
            r_action_start <= n_action_start;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
            r_cnt       <= n_cnt;
        end else if (w_out_beat) begin
            r_cnt       <= r_cnt - 2'd1;
            if (r_cnt == 2'd1) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register payload: load a fresh list or shift the queue by one beat.
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_list      <= n_list;
            r_out_phase <= n_phase;
            r_out_done  <= (n_phase == PH_DONE);
        end else if (w_out_beat) begin
            r_list[0] <= r_list[1];
            r_list[1] <= r_list[2];
        end
    end

    // Output channel.
    assign o_out.valid       = r_out_valid;
    assign o_out.motor_cmd   = r_list[0].cmd;
    assign o_out.cmd_speed   = r_list[0].speed;
    assign o_out.phase       = r_out_phase;
    assign o_out.completed   = r_out_done;
    assign o_out.last_result = (r_cnt == 2'd1);

    // A full result register always holds at least one queued beat.
    `ODS_ASSERT_IMPL(a_cnt_nonzero, i_clk, i_rst_n, r_out_valid, r_cnt != 2'd0)

    // A beat that is not the last leaves the rest of the item on the output.
    `ODS_ASSERT_NEXT(a_more_beats, i_clk, i_rst_n,
        w_out_beat && !o_out.last_result, o_out.valid)

    // The last beat with nothing held behind it empties the output.
    `ODS_ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        w_out_beat && o_out.last_result && !r_in_valid, !o_out.valid)

    // A stop or reset item always leaves the sequencer inactive.
    `ODS_ASSERT_NEXT(a_stop_inactive, i_clk, i_rst_n,
        w_move && ((r_in_func == FUNC_STOP) || (r_in_func == FUNC_RESET)),
        r_phase == PH_INACTIVE)

    // The completed flag on the output follows the reported phase.
    `ODS_ASSERT_IMPL(a_done_flag, i_clk, i_rst_n,
        r_out_valid, o_out.completed == (o_out.phase == PH_DONE))

endmodule

`default_nettype wire
